/* rtl/obb_overlap_test_unit_assert.svh */
// Assertion macros for the OBB overlap test unit.
// Used by rtl/obb_queue.sv and rtl/obb_overlap_test_unit.sv; expects clk and rst_n in scope.
`ifndef OBB_OVERLAP_TEST_UNIT_ASSERT_SVH
`define OBB_OVERLAP_TEST_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define OBB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define OBB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define OBB_ASSERT(lbl, prop, msg)
`define OBB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/obb_pkg.sv */
// Shared widths, types and queue entry layout for the OBB overlap test unit.
// No dependencies.
package obb_pkg;
  localparam int CB    = 16;
  localparam int RF    = CB - 2;
  localparam int FLD_W = 48;
  localparam int QD    = 4;
  localparam int QP_W  = $clog2(QD);
  localparam int QC_W  = $clog2(QD + 1);
  localparam int PW0   = 2 * CB;
  localparam int DW    = 2 * CB + 3;
  localparam int CW    = 2 * CB + 2;
  localparam int MW    = CB + DW;
  localparam int ADW   = MW + 2;
  localparam int EW    = CB + CW;
  localparam int RW    = EW + 3;
  localparam int FW    = ((ADW > RW) ? ADW : RW) + 1;
  localparam int SPL   = ADW / 2;
  localparam int HIW   = ADW - SPL;
  localparam int PPW   = HIW + CW + 1;
  localparam int DSW   = ADW + CW + 1;
  localparam int XW    = DSW + 1;

  typedef logic signed [CB-1:0]  comp_t;
  typedef logic signed [PW0-1:0] prod_t;
  typedef logic signed [DW-1:0]  d_t;
  typedef logic signed [CW-1:0]  c_t;
  typedef logic signed [MW-1:0]  m_t;
  typedef logic signed [ADW-1:0] ad_t;
  typedef logic signed [EW-1:0]  e_t;
  typedef logic signed [RW-1:0]  r_t;
  typedef logic signed [FW-1:0]  f_t;
  typedef logic signed [SPL:0]   lo_t;
  typedef logic signed [HIW-1:0] hi_t;
  typedef logic signed [PPW-1:0] pp_t;
  typedef logic signed [DSW-1:0] ds_t;
  typedef logic signed [XW-1:0]  x_t;

  typedef struct packed {
    logic [FLD_W-1:0] a_axis_x;
    logic [FLD_W-1:0] a_axis_y;
    logic [FLD_W-1:0] a_axis_z;
    logic [FLD_W-1:0] a_position;
    logic [FLD_W-1:0] a_center;
    logic [FLD_W-1:0] a_extent;
    logic [FLD_W-1:0] b_axis_x;
    logic [FLD_W-1:0] b_axis_y;
    logic [FLD_W-1:0] b_axis_z;
    logic [FLD_W-1:0] b_position;
    logic [FLD_W-1:0] b_center;
    logic [FLD_W-1:0] b_extent;
  } pair_t;

  typedef struct packed {
    comp_t [2:0][2:0] ax;
    comp_t [2:0][2:0] bx;
    comp_t [2:0]      ea;
    comp_t [2:0]      eb;
    d_t    [2:0]      d;
    c_t    [2:0][2:0] c;
  } qent_t;

  typedef struct packed {
    logic vld;
    logic afull;
  } qstat_t;
endpackage

/* rtl/obb_overlap_test_unit.sv */
// Top level of the OBB overlap test unit: front end, queue and back end.
// Depends on obb_pkg, obb_front, obb_queue, obb_back and the assertion header.
`include "obb_overlap_test_unit_assert.svh"
// One box pair per request, one pair per cycle sustained. out_valid pulses for
// one cycle with out_overlap once the request has passed the two-stage front
// end, one queue slot and the five-stage back end.
// The receiver cannot stall, so the queue drains every cycle and busy stays low.
module obb_overlap_test_unit import obb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [FLD_W-1:0] in_a_axis_x,
  input  logic [FLD_W-1:0] in_a_axis_y,
  input  logic [FLD_W-1:0] in_a_axis_z,
  input  logic [FLD_W-1:0] in_a_position,
  input  logic [FLD_W-1:0] in_a_center,
  input  logic [FLD_W-1:0] in_a_extent,
  input  logic [FLD_W-1:0] in_b_axis_x,
  input  logic [FLD_W-1:0] in_b_axis_y,
  input  logic [FLD_W-1:0] in_b_axis_z,
  input  logic [FLD_W-1:0] in_b_position,
  input  logic [FLD_W-1:0] in_b_center,
  input  logic [FLD_W-1:0] in_b_extent,
  output logic             out_valid,
  output logic             out_overlap
);
  pair_t  pr;
  logic   acc;
  logic   push;
  qent_t  ent;
  qent_t  qout;
  qstat_t qst;

  assign pr.a_axis_x   = in_a_axis_x;
  assign pr.a_axis_y   = in_a_axis_y;
  assign pr.a_axis_z   = in_a_axis_z;
  assign pr.a_position = in_a_position;
  assign pr.a_center   = in_a_center;
  assign pr.a_extent   = in_a_extent;
  assign pr.b_axis_x   = in_b_axis_x;
  assign pr.b_axis_y   = in_b_axis_y;
  assign pr.b_axis_z   = in_b_axis_z;
  assign pr.b_position = in_b_position;
  assign pr.b_center   = in_b_center;
  assign pr.b_extent   = in_b_extent;

  assign busy = qst.afull;
  assign acc  = start && !busy;

  obb_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .pr    (pr),
    .push  (push),
    .ent   (ent)
  );

  obb_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (ent),
    .st    (qst),
    .dout  (qout)
  );

  obb_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .st          (qst),
    .e           (qout),
    .res_v       (out_valid),
    .res_overlap (out_overlap)
  );

  `OBB_ASSERT(a_lat_fwd, (start && !busy) |-> ##8 out_valid, "result missing")
  `OBB_ASSERT(a_lat_rev, out_valid |-> $past(start && !busy, 8), "spurious result")
  `OBB_ASSERT(a_no_busy, !busy, "busy raised")
endmodule

/* rtl/obb_front.sv */
// Front end: unpacks a box pair, forms center difference D and axis dot matrix C.
// Depends on obb_pkg.
module obb_front import obb_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  acc,
  input  pair_t pr,
  output logic  push,
  output qent_t ent
);
  comp_t ax [3][3];
  comp_t bx [3][3];
  comp_t pa [3];
  comp_t pb [3];
  comp_t ca [3];
  comp_t cb [3];
  comp_t ea [3];
  comp_t eb [3];

  logic  f1_v_r;
  prod_t pac_r [3][3];
  prod_t pbc_r [3][3];
  prod_t cp_r [3][3][3];
  logic signed [CB:0] pd_r [3];
  comp_t ax_r [3][3];
  comp_t bx_r [3][3];
  comp_t ea_r [3];
  comp_t eb_r [3];

  logic  f2_v_r;
  qent_t ent_r;
  qent_t ent_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ax[0][k] = comp_t'(pr.a_axis_x[k*CB +: CB]);
      ax[1][k] = comp_t'(pr.a_axis_y[k*CB +: CB]);
      ax[2][k] = comp_t'(pr.a_axis_z[k*CB +: CB]);
      bx[0][k] = comp_t'(pr.b_axis_x[k*CB +: CB]);
      bx[1][k] = comp_t'(pr.b_axis_y[k*CB +: CB]);
      bx[2][k] = comp_t'(pr.b_axis_z[k*CB +: CB]);
      pa[k]    = comp_t'(pr.a_position[k*CB +: CB]);
      pb[k]    = comp_t'(pr.b_position[k*CB +: CB]);
      ca[k]    = comp_t'(pr.a_center[k*CB +: CB]);
      cb[k]    = comp_t'(pr.b_center[k*CB +: CB]);
      ea[k]    = comp_t'(pr.a_extent[k*CB +: CB]);
      eb[k]    = comp_t'(pr.b_extent[k*CB +: CB]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else begin
      f1_v_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pd_r[i] <= {pa[i][CB-1], pa[i]} - {pb[i][CB-1], pb[i]};
      ea_r[i] <= ea[i];
      eb_r[i] <= eb[i];
      for (int k = 0; k < 3; k++) begin
        pac_r[i][k] <= ax[i][k] * ca[i];
        pbc_r[i][k] <= bx[i][k] * cb[i];
        ax_r[i][k]  <= ax[i][k];
        bx_r[i][k]  <= bx[i][k];
        for (int j = 0; j < 3; j++) begin
          cp_r[i][j][k] <= ax[i][k] * bx[j][k];
        end
      end
    end
  end

  always_comb begin
    ent_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      ent_nxt.d[k] = d_t'(pd_r[k]) <<< RF;
      for (int i = 0; i < 3; i++) begin
        ent_nxt.d[k] = ent_nxt.d[k] + d_t'(pac_r[i][k]) - d_t'(pbc_r[i][k]);
      end
    end
    for (int i = 0; i < 3; i++) begin
      ent_nxt.ea[i] = ea_r[i];
      ent_nxt.eb[i] = eb_r[i];
      for (int j = 0; j < 3; j++) begin
        ent_nxt.ax[i][j] = ax_r[i][j];
        ent_nxt.bx[i][j] = bx_r[i][j];
        ent_nxt.c[i][j]  = c_t'(cp_r[i][j][0]) + c_t'(cp_r[i][j][1]) + c_t'(cp_r[i][j][2]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_v_r <= 1'b0;
    end else begin
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign push = f2_v_r;
  assign ent  = ent_r;
endmodule

/* rtl/obb_queue.sv */
// Short request queue between front and back ends.
// Depends on obb_pkg and obb_overlap_test_unit_assert.svh.
`include "obb_overlap_test_unit_assert.svh"
module obb_queue import obb_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  qent_t  din,
  output qstat_t st,
  output qent_t  dout
);
  qent_t q_r [QD];
  logic [QP_W-1:0] wp_r;
  logic [QP_W-1:0] rp_r;
  logic [QC_W-1:0] count_r;
  logic [QC_W-1:0] count_nxt;
  logic pop;

  // back end never stalls: drain every cycle
  assign pop       = (count_r != '0);
  assign count_nxt = count_r + QC_W'(push) - QC_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wp_r <= wp_r + QP_W'(1);
      end
      if (pop) begin
        rp_r <= rp_r + QP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= din;
    end
  end

  assign dout     = q_r[rp_r];
  assign st.vld   = pop;
  // two requests may still be in flight in the front end
  assign st.afull = (count_r >= QC_W'(QD - 2));

  `OBB_ASSERT(a_q_no_ovf, push |-> (count_r != QC_W'(QD)), "queue overflow")
  `OBB_ASSERT_NEXT(a_q_inc, push && !pop, count_r == $past(count_r) + QC_W'(1), "queue count")
  `OBB_ASSERT_NEXT(a_q_dec, pop && !push, count_r == $past(count_r) - QC_W'(1), "queue count")
endmodule

/* rtl/obb_back.sv */
// Back end: projections, radii and the 15 separating axis compares.
// Depends on obb_pkg.
module obb_back import obb_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  qstat_t st,
  input  qent_t  e,
  output logic   res_v,
  output logic   res_overlap
);
  comp_t ax [3][3];
  comp_t bx [3][3];
  d_t    dd [3];
  c_t    cc [3][3];

  logic b1_v_r, b2_v_r, b3_v_r, b4_v_r, out_v_r, out_ov_r;

  m_t    mad_r [3][3];
  m_t    mbd_r [3][3];
  c_t    c1_r [3][3];
  c_t    ac1_r [3][3];
  comp_t ea1_r [3];
  comp_t eb1_r [3];

  ad_t   ad2_r [3];
  ad_t   bd2_r [3];
  e_t    pa_r [3][3][3];
  e_t    pb_r [3][3][3];
  c_t    c2_r [3][3];
  comp_t ea2_r [3];
  comp_t eb2_r [3];

  r_t    rda_r [3];
  r_t    rdb_r [3];
  r_t    crad3_r [3][3];
  pp_t   l1_r [3][3];
  pp_t   h1_r [3][3];
  pp_t   l2_r [3][3];
  pp_t   h2_r [3][3];
  ad_t   ad3_r [3];
  ad_t   bd3_r [3];

  logic [5:0] sepf_r;
  ds_t   dist_r [3][3];
  r_t    crad4_r [3][3];

  lo_t adl [3];
  hi_t adh [3];
  f_t  fa [3];
  f_t  fb [3];
  logic sep_x;
  x_t  dx;
  x_t  rx;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dd[i] = e.d[i];
      for (int k = 0; k < 3; k++) begin
        ax[i][k] = e.ax[i][k];
        bx[i][k] = e.bx[i][k];
        cc[i][k] = e.c[i][k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r  <= 1'b0;
      b2_v_r  <= 1'b0;
      b3_v_r  <= 1'b0;
      b4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      b1_v_r  <= st.vld;
      b2_v_r  <= b1_v_r;
      b3_v_r  <= b2_v_r;
      b4_v_r  <= b3_v_r;
      out_v_r <= b4_v_r;
    end
  end

  // stage 1: axis . D products, |C|
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ea1_r[i] <= e.ea[i];
      eb1_r[i] <= e.eb[i];
      for (int k = 0; k < 3; k++) begin
        mad_r[i][k] <= ax[i][k] * dd[k];
        mbd_r[i][k] <= bx[i][k] * dd[k];
        c1_r[i][k]  <= cc[i][k];
        ac1_r[i][k] <= (cc[i][k] < 0) ? -cc[i][k] : cc[i][k];
      end
    end
  end

  // stage 2: projections, extent x |C| products
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ad2_r[i] <= ad_t'(mad_r[i][0]) + ad_t'(mad_r[i][1]) + ad_t'(mad_r[i][2]);
      bd2_r[i] <= ad_t'(mbd_r[i][0]) + ad_t'(mbd_r[i][1]) + ad_t'(mbd_r[i][2]);
      ea2_r[i] <= ea1_r[i];
      eb2_r[i] <= eb1_r[i];
      for (int j = 0; j < 3; j++) begin
        c2_r[i][j] <= c1_r[i][j];
        for (int n = 0; n < 3; n++) begin
          pa_r[i][j][n] <= ea1_r[i] * ac1_r[j][n];
          pb_r[i][j][n] <= eb1_r[i] * ac1_r[j][n];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      adl[i] = lo_t'({1'b0, ad2_r[i][SPL-1:0]});
      adh[i] = hi_t'(ad2_r[i][ADW-1:SPL]);
    end
  end

  // stage 3: radii, split partial products of the edge distances
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ad3_r[i] <= ad2_r[i];
      bd3_r[i] <= bd2_r[i];
      rda_r[i] <= (r_t'(ea2_r[i]) <<< (2 * RF)) + r_t'(pb_r[0][i][0])
                  + r_t'(pb_r[1][i][1]) + r_t'(pb_r[2][i][2]);
      rdb_r[i] <= (r_t'(eb2_r[i]) <<< (2 * RF)) + r_t'(pa_r[0][0][i])
                  + r_t'(pa_r[1][1][i]) + r_t'(pa_r[2][2][i]);
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        crad3_r[i][j] <= r_t'(pa_r[(i == 2) ? 0 : i + 1][(i == 0) ? 2 : i - 1][j])
                       + r_t'(pa_r[(i == 0) ? 2 : i - 1][(i == 2) ? 0 : i + 1][j])
                       + r_t'(pb_r[(j == 2) ? 0 : j + 1][i][(j == 0) ? 2 : j - 1])
                       + r_t'(pb_r[(j == 0) ? 2 : j - 1][i][(j == 2) ? 0 : j + 1]);
        l1_r[i][j] <= adl[(i == 0) ? 2 : i - 1] * c2_r[(i == 2) ? 0 : i + 1][j];
        h1_r[i][j] <= adh[(i == 0) ? 2 : i - 1] * c2_r[(i == 2) ? 0 : i + 1][j];
        l2_r[i][j] <= adl[(i == 2) ? 0 : i + 1] * c2_r[(i == 0) ? 2 : i - 1][j];
        h2_r[i][j] <= adh[(i == 2) ? 0 : i + 1] * c2_r[(i == 0) ? 2 : i - 1][j];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fa[i] = (ad3_r[i] < 0) ? -f_t'(ad3_r[i]) : f_t'(ad3_r[i]);
      fb[i] = (bd3_r[i] < 0) ? -f_t'(bd3_r[i]) : f_t'(bd3_r[i]);
    end
  end

  // stage 4: face compares, edge distances
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sepf_r[i]     <= fa[i] > f_t'(rda_r[i]);
      sepf_r[i + 3] <= fb[i] > f_t'(rdb_r[i]);
      for (int j = 0; j < 3; j++) begin
        crad4_r[i][j] <= crad3_r[i][j];
        dist_r[i][j]  <= ((ds_t'(h1_r[i][j]) <<< SPL) + ds_t'(l1_r[i][j]))
                       - ((ds_t'(h2_r[i][j]) <<< SPL) + ds_t'(l2_r[i][j]));
      end
    end
  end

  // stage 5: edge compares and final verdict
  always_comb begin
    sep_x = 1'b0;
    dx    = '0;
    rx    = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        dx = (dist_r[i][j] < 0) ? -x_t'(dist_r[i][j]) : x_t'(dist_r[i][j]);
        rx = x_t'(crad4_r[i][j]) <<< (2 * RF);
        if (dx > rx) begin
          sep_x = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_ov_r <= !(|sepf_r) && !sep_x;
  end

  assign res_v       = out_v_r;
  assign res_overlap = out_ov_r;
endmodule
